@@ rtl/tle_pkg.sv @@
package tle_pkg;

  localparam int LINE_LEN = 64;
  localparam int IDX_W    = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
  localparam int POS_W    = $clog2(LINE_LEN + 1);
  localparam int SLOT_W   = 6;
  localparam int Q_DEPTH  = 4;
  localparam int QPTR_W   = $clog2(Q_DEPTH);
  localparam int QCNT_W   = $clog2(Q_DEPTH + 1);
  localparam int STEP_W   = 3;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_NUL   = 8'd0;

  typedef enum logic [1:0] {
    OP_CHAR,
    OP_CR,
    OP_BS,
    OP_READ
  } tle_op_t;

  typedef struct packed {
    tle_op_t    op;
    logic [7:0] data;
    logic       ready;
  } tle_cmd_t;

  // widen or cut a read slot to a store index
  function automatic logic [IDX_W-1:0] slot_to_idx(input logic [SLOT_W-1:0] s);
    logic [SLOT_W+IDX_W-1:0] w;
    w = {{IDX_W{1'b0}}, s};
    return w[IDX_W-1:0];
  endfunction

  function automatic logic slot_in_range(input logic [SLOT_W-1:0] s);
    return (SLOT_W + POS_W)'(s) < (SLOT_W + POS_W)'(LINE_LEN);
  endfunction

  // echo byte for one step of a command
  function automatic logic [7:0] echo_byte(input tle_op_t op, input logic [STEP_W-1:0] step,
                                           input logic [7:0] data);
    logic [7:0] b;
    b = data;
    unique case (op)
      OP_CR: begin
        unique case (step)
          3'd0:    b = CH_LF;
          3'd1:    b = CH_CR;
          default: b = CH_NUL;
        endcase
      end
      OP_BS: begin
        unique case (step)
          3'd0, 3'd3, 3'd5: b = CH_BS;
          3'd1, 3'd2:       b = CH_SPACE;
          default:          b = CH_NUL;
        endcase
      end
      OP_CHAR, OP_READ: b = data;
      default: b = data;
    endcase
    return b;
  endfunction

  function automatic logic echo_last(input tle_op_t op, input logic [STEP_W-1:0] step);
    logic l;
    l = 1'b1;
    unique case (op)
      OP_CR:   l = (step == 3'd2);
      OP_BS:   l = (step == 3'd5);
      default: l = 1'b1;
    endcase
    return l;
  endfunction

endpackage

@@ rtl/terminal_line_editor_with_echo.sv @@
// First result word of an item passes the front stage register, the queue and the output register before m_tvalid.
// Throughput: one result word per cycle while m_tready is high; an item gives one (plain byte,
//   read), three (carriage return) or six (backspace) result words, set by the echo sequencer;
//   a 4-entry command queue lets the front take one item per cycle while it has room.
// Reset (rst, synchronous): position, ready flag, per-slot valid bits (store reads zero),
//   queue and output valid are cleared at once; no clearing pass.
module terminal_line_editor_with_echo import tle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] rx_byte, [13:8] read_slot, [15:14] zero
  input  logic        s_tuser,   // [0] kind
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] data_byte, [8] line_ready, [15:9] zero
  output logic        m_tuser,   // [0] result_kind
  output logic        m_tlast    // last word caused by one input word
);

  // front -> queue
  logic     push;
  tle_cmd_t push_cmd;
  logic     q_full;
  // queue -> back
  logic     q_valid;
  tle_cmd_t q_cmd;
  logic     pop;

  logic [7:0] data_byte;
  logic       line_ready;

  // Front: decode the word, update position, ready flag and line store, and
  // hand one command per word to the queue. Reads see the store in order.
  tle_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_kind  (s_tuser),
    .in_rx    (s_tdata[7:0]),
    .in_slot  (s_tdata[8 +: SLOT_W]),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  // Short queue: decouple decoding from echo draining.
  tle_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop)
  );

  // Back: expand each command into its echo sequence through an output register.
  tle_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .pop            (pop),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_kind       (m_tuser),
    .out_data       (data_byte),
    .out_line_ready (line_ready),
    .out_last       (m_tlast)
  );

  assign m_tdata = {7'd0, line_ready, data_byte};

endmodule

@@ rtl/tle_front.sv @@
module tle_front import tle_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_kind,
  input  logic [7:0]       in_rx,
  input  logic [SLOT_W-1:0] in_slot,
  output logic             push,
  output tle_cmd_t         push_cmd,
  input  logic             q_full
);

  logic [7:0]          mem [LINE_LEN];
  logic [LINE_LEN-1:0] valid;
  logic [LINE_LEN-1:0] valid_next;
  logic [POS_W-1:0]    wp;
  logic [POS_W-1:0]    wp_next;
  logic                ready_flag;
  logic                ready_flag_next;
  logic                acc;

  logic                st_valid;
  tle_op_t             st_op;
  logic [7:0]          st_data;
  logic                st_ready;
  logic                st_hit;
  logic [7:0]          rd_q;

  tle_op_t             op_c;
  logic                we;
  logic [7:0]          wdata;
  logic [IDX_W-1:0]    widx;
  logic [IDX_W-1:0]    ridx;
  logic                room;
  logic                is_cr;
  logic                is_bs;

  assign acc      = in_valid && in_ready;
  assign push     = st_valid && !q_full;
  assign in_ready = !st_valid || !q_full;
  assign room     = wp < POS_W'(LINE_LEN);
  assign widx     = wp[IDX_W-1:0];
  assign ridx     = slot_to_idx(in_slot);
  assign is_cr    = (in_rx == CH_CR);
  assign is_bs    = (in_rx == CH_BS) && (wp != '0);

  always_comb begin
    valid_next      = valid;
    wp_next         = wp;
    ready_flag_next = ready_flag;
    we              = 1'b0;
    wdata           = in_rx;
    op_c            = OP_READ;
    if (!in_kind) begin
      if (wp == '0) begin
        valid_next      = '0;
        ready_flag_next = 1'b0;
      end
      priority if (is_cr) begin
        op_c            = OP_CR;
        we              = room;
        wp_next         = '0;
        ready_flag_next = 1'b1;
      end else if (is_bs) begin
        // drop the slot at the position by marking it empty
        op_c    = OP_BS;
        wp_next = wp - POS_W'(1);
      end else begin
        op_c = OP_CHAR;
        we   = room;
        if (room) begin
          wp_next = wp + POS_W'(1);
        end
      end
      if (room && (is_cr || is_bs || op_c == OP_CHAR)) begin
        valid_next[widx] = !is_bs || is_cr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      wp         <= '0;
      ready_flag <= 1'b0;
      st_valid   <= 1'b0;
    end else begin
      if (acc) begin
        valid      <= valid_next;
        wp         <= wp_next;
        ready_flag <= ready_flag_next;
        st_valid   <= 1'b1;
      end else if (push) begin
        st_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      st_op    <= op_c;
      st_data  <= in_rx;
      st_ready <= in_kind ? ready_flag : ready_flag_next;
      st_hit   <= slot_in_range(in_slot) && valid[ridx];
    end
  end

  // store port: one write, one registered read
  always_ff @(posedge clk) begin
    if (acc && we) begin
      mem[widx] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_kind) begin
      rd_q <= mem[ridx];
    end
  end

  always_comb begin
    push_cmd.op    = st_op;
    push_cmd.ready = st_ready;
    push_cmd.data  = (st_op == OP_READ) ? (st_hit ? rd_q : 8'd0) : st_data;
  end

  assert property (@(posedge clk) disable iff (rst) wp <= POS_W'(LINE_LEN))
    else $error("write position past the store");

  assert property (@(posedge clk) disable iff (rst)
    acc && !in_kind && is_cr |=> (wp == '0) && ready_flag && st_valid)
    else $error("carriage return did not close the line");

endmodule

@@ rtl/tle_queue.sv @@
module tle_queue import tle_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  tle_cmd_t push_cmd,
  output logic     full,
  output logic     q_valid,
  output tle_cmd_t q_cmd,
  input  logic     pop
);

  tle_cmd_t          slots [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = (count == QCNT_W'(Q_DEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(push && full) && !(pop && !q_valid))
    else $error("queue overrun or underrun");

endmodule

@@ rtl/tle_back.sv @@
module tle_back import tle_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_valid,
  input  tle_cmd_t q_cmd,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_ready,
  output logic     out_kind,
  output logic [7:0] out_data,
  output logic     out_line_ready,
  output logic     out_last
);

  logic [STEP_W-1:0] step;
  logic              load;
  logic              last_c;

  assign load   = !out_valid || out_ready;
  assign last_c = echo_last(q_cmd.op, step);
  assign pop    = load && q_valid && last_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else if (load) begin
      out_valid <= q_valid;
      if (q_valid) begin
        step <= last_c ? '0 : step + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      out_kind       <= (q_cmd.op == OP_READ);
      out_data       <= echo_byte(q_cmd.op, step, q_cmd.data);
      out_line_ready <= q_cmd.ready;
      out_last       <= last_c;
    end
  end

  assert property (@(posedge clk) disable iff (rst) (step != '0) |-> q_valid && step < 3'd6)
    else $error("echo step without a command");

endmodule
